[rtl/fat_chain_allocator_top_macros.svh]
// Assertion shorthands shared by the allocator modules.
// Each expects signals named clock and reset in the module that uses it.
`ifndef FAT_CHAIN_ALLOCATOR_TOP_MACROS_SVH
`define FAT_CHAIN_ALLOCATOR_TOP_MACROS_SVH

// Property that must hold at every edge outside reset
`define FCA_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Same-cycle implication
`define FCA_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

[rtl/fca_pkg.sv]
package fca_pkg;

   // Field widths of the request and response words
   localparam int MODE_W   = 2;
   localparam int LEN_W    = 31;
   localparam int START_W  = 10;
   localparam int STATUS_W = 2;
   localparam int BLK_W    = 10;
   localparam int FREE_W   = 11;

   // Default sizing
   localparam int DEF_NUM_BLOCKS  = 1024;
   localparam int DEF_BLOCK_BYTES = 1024;

   typedef enum logic [MODE_W-1:0] {
      MODE_ALLOC  = 2'd0,
      MODE_FREE   = 2'd1,
      MODE_FOLLOW = 2'd2
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_INSUF = 2'd1,
      STAT_BAD   = 2'd2
   } status_type;

   typedef struct packed {
      mode_type           mode;
      logic [LEN_W-1:0]   file_length;
      logic [START_W-1:0] start_block;
   } req_word_type;

   typedef struct packed {
      status_type        status;
      logic [BLK_W-1:0]  block_index;
      logic              chain_end;
      logic [FREE_W-1:0] avail_blocks;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ALLOC_CHK,
      ST_ALLOC_SCAN,
      ST_ALLOC_END,
      ST_FREE_WALK,
      ST_FOLLOW,
      ST_RESP
   } state_type;

endpackage

[rtl/fca_stream_if.sv]
// Valid/ready channel carrying one word per handshake
interface fca_stream_if #(parameter type word_type = logic);
   logic     valid;
   logic     ready;
   word_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

[rtl/fca_table.sv]
// Allocation table storage: one write port, one read port, registered read
module fca_table #(
   parameter int NUM_BLOCKS = fca_pkg::DEF_NUM_BLOCKS,
   localparam int AW = $clog2(NUM_BLOCKS),
   localparam int EW = $clog2(NUM_BLOCKS + 2)
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [EW-1:0] rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [EW-1:0] wr_data
);

   logic [EW-1:0] mem [NUM_BLOCKS];
   logic [EW-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, new data wins on a same-address collision
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/fca_ctrl.sv]
`include "fat_chain_allocator_top_macros.svh"

// Request sequencer: clear sweep, allocate scan, free walk, follow, response
module fca_ctrl #(
   parameter int NUM_BLOCKS  = fca_pkg::DEF_NUM_BLOCKS,
   parameter int BLOCK_BYTES = fca_pkg::DEF_BLOCK_BYTES,
   localparam int AW = $clog2(NUM_BLOCKS),
   localparam int EW = $clog2(NUM_BLOCKS + 2)
) (
   input  logic          clock,
   input  logic          reset,
   fca_stream_if.sink    req_if,
   fca_stream_if.source  rsp_if,
   output logic          rd_en,
   output logic [AW-1:0] rd_addr,
   input  logic [EW-1:0] rd_data,
   output logic          wr_en,
   output logic [AW-1:0] wr_addr,
   output logic [EW-1:0] wr_data
);

   import fca_pkg::*;

   localparam int CW     = $clog2(NUM_BLOCKS + 1);
   localparam int BBW    = $clog2(BLOCK_BYTES + 1);
   localparam int PROD_W = CW + BBW;
   localparam int CMP_W  = (PROD_W > LEN_W) ? PROD_W : LEN_W;

   localparam logic [EW-1:0] ENT_END  = EW'(NUM_BLOCKS);
   localparam logic [EW-1:0] ENT_FREE = EW'(NUM_BLOCKS + 1);
   localparam logic [AW:0]   SCAN_LIM = (AW + 1)'(NUM_BLOCKS);
   localparam logic [AW:0]   SCAN_TOP = (AW + 1)'(NUM_BLOCKS - 1);
   localparam logic [LEN_W-1:0] BB_LEN = LEN_W'(BLOCK_BYTES);

   state_type         state_ff, state_in;
   logic [AW:0]       scan_ff, scan_in;
   logic [AW-1:0]     chk_ff, chk_in;
   logic              pend_ff, pend_in;
   logic [LEN_W-1:0]  rem_ff, rem_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [CW-1:0]     fc_ff, fc_in;
   logic [AW-1:0]     prev_ff, prev_in;
   logic              have_prev_ff, have_prev_in;
   logic [AW-1:0]     first_ff, first_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic              walk_first_ff, walk_first_in;
   rsp_word_type      res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_word_ff, rsp_word_in;

   logic              accept;
   logic              start_bad;
   req_word_type      req;

   assign req       = req_if.word;
   assign accept    = req_if.valid && req_if.ready;
   assign start_bad = 32'(req.start_block) >= 32'(NUM_BLOCKS);

   assign req_if.ready = (state_ff == ST_IDLE);
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.word  = rsp_word_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         scan_ff      <= '0;
         pend_ff      <= 1'b0;
         fc_ff        <= CW'(NUM_BLOCKS);
         have_prev_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         pend_ff      <= pend_in;
         fc_ff        <= fc_in;
         have_prev_ff <= have_prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers
   always_ff @(posedge clock) begin
      chk_ff        <= chk_in;
      rem_ff        <= rem_in;
      prod_ff       <= prod_in;
      prev_ff       <= prev_in;
      first_ff      <= first_in;
      idx_ff        <= idx_in;
      walk_first_ff <= walk_first_in;
      res_ff        <= res_in;
      rsp_word_ff   <= rsp_word_in;
   end

   // Next state and table access
   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      chk_in        = chk_ff;
      pend_in       = pend_ff;
      rem_in        = rem_ff;
      prod_in       = prod_ff;
      fc_in         = fc_ff;
      prev_in       = prev_ff;
      have_prev_in  = have_prev_ff;
      first_in      = first_ff;
      idx_in        = idx_ff;
      walk_first_in = walk_first_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_word_in   = rsp_word_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = ENT_FREE;

      // Output register drains independently
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         // Sweep every entry to free after reset
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = scan_ff[AW-1:0];
            wr_data = ENT_FREE;
            if (scan_ff == SCAN_TOP) begin
               scan_in  = '0;
               state_in = ST_IDLE;
            end else begin
               scan_in = scan_ff + (AW + 1)'(1);
            end
         end

         ST_IDLE: begin
            if (accept) begin
               res_in.status       = STAT_OK;
               res_in.block_index  = '0;
               res_in.chain_end    = 1'b0;
               res_in.avail_blocks = '0;
               case (req.mode)
                  MODE_ALLOC: begin
                     rem_in   = req.file_length;
                     prod_in  = PROD_W'(fc_ff) * PROD_W'(BLOCK_BYTES);
                     state_in = ST_ALLOC_CHK;
                  end
                  MODE_FREE, MODE_FOLLOW: begin
                     if (start_bad) begin
                        res_in.status = STAT_BAD;
                        state_in      = ST_RESP;
                     end else begin
                        rd_en         = 1'b1;
                        rd_addr       = AW'(req.start_block);
                        idx_in        = AW'(req.start_block);
                        walk_first_in = 1'b1;
                        state_in      = (req.mode == MODE_FREE) ? ST_FREE_WALK : ST_FOLLOW;
                     end
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end

         // Enough free blocks: at least one must be free, and length must not exceed free_count * block size
         ST_ALLOC_CHK: begin
            if ((fc_ff == '0) || (CMP_W'(rem_ff) > CMP_W'(prod_ff))) begin
               res_in.status = STAT_INSUF;
               state_in      = ST_RESP;
            end else begin
               scan_in      = '0;
               pend_in      = 1'b0;
               have_prev_in = 1'b0;
               state_in     = ST_ALLOC_SCAN;
            end
         end

         // One entry read per cycle; a free hit links the previous block to it
         ST_ALLOC_SCAN: begin
            pend_in = 1'b0;
            if (scan_ff < SCAN_LIM) begin
               rd_en   = 1'b1;
               rd_addr = scan_ff[AW-1:0];
               chk_in  = scan_ff[AW-1:0];
               pend_in = 1'b1;
               scan_in = scan_ff + (AW + 1)'(1);
            end
            if (pend_ff && (rd_data == ENT_FREE)) begin
               if (have_prev_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = prev_ff;
                  wr_data = EW'(chk_ff);
               end else begin
                  first_in = chk_ff;
               end
               prev_in      = chk_ff;
               have_prev_in = 1'b1;
               fc_in        = fc_ff - CW'(1);
               if (rem_ff <= BB_LEN) begin
                  pend_in  = 1'b0;
                  state_in = ST_ALLOC_END;
               end else begin
                  rem_in = rem_ff - BB_LEN;
               end
            end else if (!pend_ff && (scan_ff == SCAN_LIM)) begin
               state_in = ST_ALLOC_END;
            end
         end

         // Terminate the chain at its last block
         ST_ALLOC_END: begin
            if (have_prev_ff) begin
               wr_en   = 1'b1;
               wr_addr = prev_ff;
               wr_data = ENT_END;
            end
            res_in.block_index = BLK_W'(first_ff);
            state_in           = ST_RESP;
         end

         // Free one chain entry per cycle, next read issued from the link
         ST_FREE_WALK: begin
            walk_first_in = 1'b0;
            if (rd_data == ENT_FREE) begin
               res_in.status = walk_first_ff ? STAT_BAD : STAT_OK;
               state_in      = ST_RESP;
            end else begin
               wr_en   = 1'b1;
               wr_addr = idx_ff;
               wr_data = ENT_FREE;
               fc_in   = fc_ff + CW'(1);
               if (rd_data >= ENT_END) begin
                  state_in = ST_RESP;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = AW'(rd_data);
                  idx_in  = AW'(rd_data);
               end
            end
         end

         ST_FOLLOW: begin
            if (rd_data == ENT_FREE) begin
               res_in.status = STAT_BAD;
            end else if (rd_data >= ENT_END) begin
               res_in.chain_end = 1'b1;
            end else begin
               res_in.block_index = BLK_W'(rd_data);
            end
            state_in = ST_RESP;
         end

         // Load the output register once it is free
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_word_in              = res_ff;
               rsp_word_in.avail_blocks = FREE_W'(fc_ff);
               rsp_valid_in             = 1'b1;
               state_in                 = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `FCA_ASSERT_ALWAYS(a_fc_range, fc_ff <= CW'(NUM_BLOCKS), "free count above table size")
   `FCA_ASSERT_IMPL(a_idle_no_write, state_ff == ST_IDLE, !wr_en, "table write while idle")
   `FCA_ASSERT_IMPL(a_rsp_src, $rose(rsp_valid_ff), $past(state_ff) == ST_RESP, "stray response")
   `FCA_ASSERT_IMPL(a_clear_no_accept, state_ff == ST_CLEAR, !req_if.ready, "request taken during clear sweep")

endmodule

[rtl/fat_chain_allocator_top.sv]
// Allocate: one table entry scanned per cycle, up to the last block taken.
// Free: one entry per cycle over the table read port.
// One request at a time.
// Response adds one output register stage.
// Reset clears the count to all blocks free, then sweeps the table free one entry per cycle
// with requests held off.
module fat_chain_allocator_top #(
   parameter int NUM_BLOCKS  = fca_pkg::DEF_NUM_BLOCKS,
   parameter int BLOCK_BYTES = fca_pkg::DEF_BLOCK_BYTES
) (
   input  logic         clock,
   input  logic         reset,
   fca_stream_if.sink   req_if,
   fca_stream_if.source rsp_if
);

   import fca_pkg::*;

   localparam int AW = $clog2(NUM_BLOCKS);
   localparam int EW = $clog2(NUM_BLOCKS + 2);

   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [EW-1:0] rd_data;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [EW-1:0] wr_data;

   fca_ctrl #(
      .NUM_BLOCKS  (NUM_BLOCKS),
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .rsp_if  (rsp_if),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   fca_table #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_table (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;
   import fca_pkg::*;

   localparam int NUM_BLOCKS  = DEF_NUM_BLOCKS;
   localparam int BLOCK_BYTES = DEF_BLOCK_BYTES;
   localparam int CYCLE_LIMIT = 5_000_000;
   localparam int HOLD_CYCLES = 2000;
   localparam int LOW_SPACE   = 600;
   localparam int N_ROWS      = 26;

   // Table entry codes: END and FREE sit just past the last block index
   localparam logic [FREE_W-1:0] LINK_END  = FREE_W'(NUM_BLOCKS);
   localparam logic [FREE_W-1:0] LINK_FREE = FREE_W'(NUM_BLOCKS + 1);
   // Mode value with no operation behind it
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [LEN_W-1:0]  len;
      logic [BLK_W-1:0]  start;
      logic              typed;
      status_type        st;
      logic [BLK_W-1:0]  blk;
      logic              last;
      logic [FREE_W-1:0] free;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fca_stream_if #(.word_type(req_word_type)) req_ch ();
   fca_stream_if #(.word_type(rsp_word_type)) rsp_ch ();

   fat_chain_allocator_top #(
      .NUM_BLOCKS  (NUM_BLOCKS),
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always #4 clock = ~clock;

   // Predicted allocation table and free count
   logic [FREE_W-1:0] fat_entry [NUM_BLOCKS];
   int                free_total;
   int                chain_heads [$];
   rsp_word_type      pending_replies [$];
   dir_row_type       directed_rows [N_ROWS];

   int  fail_count = 0;
   int  cycle_count = 0;
   int  words_checked = 0;
   int  n_alloc = 0, n_insuf = 0, n_free = 0, n_follow = 0, n_bad = 0;
   bit  sender_idles = 1'b1;
   bit  receiver_idles = 1'b1;
   int  hold_asked = 0;
   int  hold_served = 0;
   int  hold_left = 0;
   int  stall_left = 0;
   rsp_word_type want;

   // Apply one request to the predicted table, return the reply word
   function automatic rsp_word_type fat_apply(req_word_type w);
      rsp_word_type r;
      longint       need;
      int           got, prev, idx, steps;
      bit           have_prev;
      logic [FREE_W-1:0] nxt;
      r = '0;
      r.status = STAT_OK;
      case (w.mode)
         MODE_ALLOC: begin
            need = longint'(w.file_length) / BLOCK_BYTES;
            if (longint'(w.file_length) % BLOCK_BYTES != 0 || w.file_length == 0)
               need++;
            if (longint'(free_total) < need) begin
               r.status = STAT_INSUF;
            end else begin
               got = 0;
               prev = 0;
               have_prev = 1'b0;
               // first fit, ascending
               for (int i = 0; i < NUM_BLOCKS && got < need; i++) begin
                  if (fat_entry[i] != LINK_FREE) continue;
                  if (have_prev) fat_entry[prev] = FREE_W'(i);
                  else r.block_index = BLK_W'(i);
                  fat_entry[i] = LINK_END;
                  prev = i;
                  have_prev = 1'b1;
                  got++;
                  free_total--;
               end
            end
         end
         MODE_FREE: begin
            if (fat_entry[w.start_block] == LINK_FREE) begin
               r.status = STAT_BAD;
            end else begin
               idx = w.start_block;
               // walk stops at chain end, at a free link, or after a full lap
               for (steps = 0; steps < NUM_BLOCKS; steps++) begin
                  nxt = fat_entry[idx];
                  if (nxt == LINK_FREE) break;
                  fat_entry[idx] = LINK_FREE;
                  free_total++;
                  if (nxt >= LINK_END) break;
                  idx = nxt;
               end
            end
         end
         MODE_FOLLOW: begin
            nxt = fat_entry[w.start_block];
            if (nxt == LINK_FREE) r.status = STAT_BAD;
            else if (nxt >= LINK_END) r.chain_end = 1'b1;
            else r.block_index = nxt[BLK_W-1:0];
         end
         default: ;
      endcase
      r.avail_blocks = FREE_W'(free_total);
      return r;
   endfunction

   function automatic logic [LEN_W-1:0] alloc_length();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return LEN_W'($urandom_range(0, 4 * BLOCK_BYTES));
      if (pick < 75) return LEN_W'($urandom_range(0, 16) * BLOCK_BYTES);
      if (pick < 90) return LEN_W'($urandom_range(0, 64 * BLOCK_BYTES));
      return LEN_W'($urandom());
   endfunction

   // Mostly allocate / follow / free over live chains, plus some noise
   function automatic req_word_type next_random_request();
      req_word_type w;
      int unsigned  pick;
      int           k, b, steps;
      w.mode        = MODE_ALLOC;
      w.file_length = LEN_W'($urandom());
      w.start_block = BLK_W'($urandom_range(0, NUM_BLOCKS - 1));
      pick = $urandom_range(0, 99);
      if (free_total < LOW_SPACE) pick = 40;
      if (chain_heads.size() == 0 && pick >= 35 && pick < 85) begin
         if (free_total < LOW_SPACE) begin
            // no tracked head left: free whatever is in use first
            w.mode = MODE_FREE;
            for (int i = NUM_BLOCKS - 1; i >= 0; i--)
               if (fat_entry[i] != LINK_FREE) w.start_block = BLK_W'(i);
            return w;
         end
         pick = 0;
      end
      if (pick < 35) begin
         w.file_length = alloc_length();
      end else if (pick < 60) begin
         k = $urandom_range(0, chain_heads.size() - 1);
         w.mode = MODE_FREE;
         w.start_block = BLK_W'(chain_heads[k]);
         chain_heads.delete(k);
      end else if (pick < 85) begin
         k = $urandom_range(0, chain_heads.size() - 1);
         b = chain_heads[k];
         steps = (pick < 80) ? $urandom_range(0, 4) : $urandom_range(1, 4);
         repeat (steps) if (fat_entry[b] < LINK_END) b = fat_entry[b];
         // a free from mid-chain leaves a dangling link behind
         w.mode = (pick < 80) ? MODE_FOLLOW : MODE_FREE;
         w.start_block = BLK_W'(b);
      end else if (pick < 95) begin
         w.mode = ($urandom_range(0, 1) == 0) ? MODE_FREE : MODE_FOLLOW;
      end else begin
         w.mode = mode_type'(MODE_UNUSED);
      end
      return w;
   endfunction

   // Offer one word, wait for acceptance, log its predicted reply
   task automatic send_request(input req_word_type w, input bit typed,
                               input rsp_word_type typed_rsp);
      rsp_word_type r;
      req_ch.valid <= 1'b1;
      req_ch.word  <= w;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      r = fat_apply(w);
      if (w.mode == MODE_ALLOC && r.status == STAT_OK)
         chain_heads.push_back(r.block_index);
      if (w.mode == MODE_ALLOC && r.status == STAT_OK) n_alloc++;
      if (r.status == STAT_INSUF) n_insuf++;
      if (r.status == STAT_BAD) n_bad++;
      if (w.mode == MODE_FREE && r.status == STAT_OK) n_free++;
      if (w.mode == MODE_FOLLOW && r.status == STAT_OK) n_follow++;
      pending_replies.push_back(typed ? typed_rsp : r);
   endtask

   task automatic sender_gap();
      int unsigned n;
      if (sender_idles && $urandom_range(0, 99) < 30) begin
         n = ($urandom_range(0, 99) < 88) ? $urandom_range(1, 3) : $urandom_range(20, 90);
         req_ch.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic issue_random(input int count);
      req_word_type w;
      int           done;
      done = 0;
      while (done < count) begin
         w = next_random_request();
         send_request(w, 1'b0, '0);
         if (w.mode != mode_type'(MODE_UNUSED)) done++;
         sender_gap();
      end
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   // Receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left--;
      end else if (hold_served != hold_asked) begin
         hold_served = hold_asked;
         hold_left = HOLD_CYCLES - 1;
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left--;
      end else if (receiver_idles && $urandom_range(0, 99) < 25) begin
         stall_left = ($urandom_range(0, 99) < 88) ? $urandom_range(0, 2)
                                                   : $urandom_range(20, 90);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Reply checker
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_replies.size() == 0) begin
            $error("reply word with none outstanding");
            fail_count++;
         end else begin
            want = pending_replies.pop_front();
            words_checked++;
            if (rsp_ch.word.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_ch.word.status);
               fail_count++;
            end
            if (rsp_ch.word.block_index !== want.block_index) begin
               $error("block_index: expected %0d, got %0d",
                      want.block_index, rsp_ch.word.block_index);
               fail_count++;
            end
            if (rsp_ch.word.chain_end !== want.chain_end) begin
               $error("chain_end: expected %0d, got %0d", want.chain_end, rsp_ch.word.chain_end);
               fail_count++;
            end
            if (rsp_ch.word.avail_blocks !== want.avail_blocks) begin
               $error("avail_blocks: expected %0d, got %0d",
                      want.avail_blocks, rsp_ch.word.avail_blocks);
               fail_count++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      req_word_type w;
      rsp_word_type t;
      req_ch.valid = 1'b0;
      req_ch.word  = '0;
      for (int i = 0; i < NUM_BLOCKS; i++) fat_entry[i] = LINK_FREE;
      free_total = NUM_BLOCKS;

      // mode, length, start, typed, status, block, end, free
      directed_rows = '{
         '{MODE_FOLLOW, 31'd0, 10'd0, 1'b1, STAT_BAD, 10'd0, 1'b0, 11'd1024},
         '{MODE_FREE, 31'd0, 10'd1023, 1'b1, STAT_BAD, 10'd0, 1'b0, 11'd1024},
         '{MODE_ALLOC, 31'd0, 10'd0, 1'b1, STAT_OK, 10'd0, 1'b0, 11'd1023},
         '{MODE_ALLOC, 31'd1, 10'd0, 1'b0, STAT_OK, 10'd0, 1'b0, 11'd0},
         '{MODE_ALLOC, 31'd1024, 10'd0, 1'b0, STAT_OK, 10'd0, 1'b0, 11'd0},
         '{MODE_ALLOC, 31'd1025, 10'd0, 1'b0, STAT_OK, 10'd0, 1'b0, 11'd0},
         '{MODE_ALLOC, 31'h7FFF_FFFF, 10'd0, 1'b1, STAT_INSUF, 10'd0, 1'b0, 11'd1019},
         '{MODE_FOLLOW, 31'd0, 10'd3, 1'b0, STAT_OK, 10'd0, 1'b0, 11'd0},
         '{MODE_FOLLOW, 31'd0, 10'd4, 1'b0, STAT_OK, 10'd0, 1'b0, 11'd0},
         '{MODE_UNUSED, 31'h7FFF_FFFF, 10'd1023, 1'b1, STAT_OK, 10'd0, 1'b0, 11'd1019},
         '{MODE_FREE, 31'd0, 10'd3, 1'b0, STAT_OK, 10'd0, 1'b0, 11'd0},
         '{MODE_FOLLOW, 31'd0, 10'd3, 1'b1, STAT_BAD, 10'd0, 1'b0, 11'd1021},
         '{MODE_ALLOC, 31'd2048, 10'd0, 1'b0, STAT_OK, 10'd0, 1'b0, 11'd0},
         '{MODE_ALLOC, 31'd1044480, 10'd0, 1'b1, STAT_INSUF, 10'd0, 1'b0, 11'd1019},
         '{MODE_ALLOC, 31'd1043456, 10'd0, 1'b1, STAT_OK, 10'd5, 1'b0, 11'd0},
         '{MODE_ALLOC, 31'd0, 10'd0, 1'b1, STAT_INSUF, 10'd0, 1'b0, 11'd0},
         '{MODE_FREE, 31'd0, 10'd0, 1'b0, STAT_OK, 10'd0, 1'b0, 11'd0},
         '{MODE_FREE, 31'd0, 10'd5, 1'b0, STAT_OK, 10'd0, 1'b0, 11'd0},
         '{MODE_FREE, 31'd0, 10'd1, 1'b0, STAT_OK, 10'd0, 1'b0, 11'd0},
         '{MODE_FREE, 31'd0, 10'd2, 1'b0, STAT_OK, 10'd0, 1'b0, 11'd0},
         '{MODE_FREE, 31'd0, 10'd3, 1'b0, STAT_OK, 10'd0, 1'b0, 11'd0},
         '{MODE_FOLLOW, 31'd0, 10'd1023, 1'b1, STAT_BAD, 10'd0, 1'b0, 11'd1024},
         '{MODE_ALLOC, 31'd3072, 10'd0, 1'b0, STAT_OK, 10'd0, 1'b0, 11'd0},
         '{MODE_FREE, 31'd0, 10'd1, 1'b0, STAT_OK, 10'd0, 1'b0, 11'd0},
         '{MODE_FOLLOW, 31'd0, 10'd0, 1'b0, STAT_OK, 10'd0, 1'b0, 11'd0},
         '{MODE_FREE, 31'd0, 10'd0, 1'b0, STAT_OK, 10'd0, 1'b0, 11'd0}
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed rows: extremes, error codes, chain edges
      foreach (directed_rows[i]) begin
         w.mode         = mode_type'(directed_rows[i].mode);
         w.file_length  = directed_rows[i].len;
         w.start_block  = directed_rows[i].start;
         t.status       = directed_rows[i].st;
         t.block_index  = directed_rows[i].blk;
         t.chain_end    = directed_rows[i].last;
         t.avail_blocks = directed_rows[i].free;
         send_request(w, directed_rows[i].typed, t);
         sender_gap();
      end

      // random traffic with idling on both sides
      issue_random(200);

      // back-to-back stretch, no idling
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      issue_random(120);

      // receiver holds off while requests keep coming
      hold_asked++;
      issue_random(8);

      // sender waits for every reply before going on
      wait_drained();
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      issue_random(230);

      req_ch.valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("checked %0d reply words: %0d allocations, %0d refused for space",
               words_checked, n_alloc, n_insuf);
      $display("%0d chain frees, %0d follows, %0d bad-block replies, %0d free blocks at end",
               n_free, n_follow, n_bad, free_total);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
